[src/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers for the URL percent decoder
// Character constants, lookahead states, the job record that the front end
// hands to the back end, and the hex classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSpace   = 8'h20;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_e;

  // One accepted input byte worth of decoded output: 1 to 3 bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'd48) && (c <= 8'd57)) ||
           ((c >= 8'd65) && (c <= 8'd70)) ||
           ((c >= 8'd97) && (c <= 8'd102));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= 8'd65) && (c <= 8'd70)) begin
      v = c - 8'd55;
    end else if ((c >= 8'd97) && (c <= 8'd102)) begin
      v = c - 8'd87;
    end else if ((c >= 8'd48) && (c <= 8'd57)) begin
      v = c - 8'd48;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[src/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front: input classifier
// Tracks the '%' lookahead and turns each accepted byte into a job of 0 to 3
// output bytes; non-empty jobs are pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          plus_to_space_i,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_last_i,
  output      logic          push_o,
  output      upd_pkg::job_t push_job_o,
  input  wire logic          q_full_i
);
  import upd_pkg::*;

  held_e      held_q, held_d;
  logic [7:0] digit_q, digit_d;
  job_t       job;
  logic [1:0] n;
  logic       do_fresh;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    job      = '0;
    n        = 2'd0;
    held_d   = HELD_NONE;
    digit_d  = digit_q;
    do_fresh = 1'b0;
    unique case (held_q)
      HELD_PCT: begin
        if (is_hex(in_byte_i) && !in_last_i) begin
          digit_d = in_byte_i;
          held_d  = HELD_DIGIT;
        end else if (is_hex(in_byte_i)) begin
          job.bytes[0] = CharPercent;
          job.bytes[1] = in_byte_i;
          n = 2'd2;
        end else begin
          job.bytes[0] = CharPercent;
          n = 2'd1;
          do_fresh = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (is_hex(in_byte_i)) begin
          job.bytes[0] = {nibble(digit_q), nibble(in_byte_i)};
          n = 2'd1;
        end else begin
          job.bytes[0] = CharPercent;
          job.bytes[1] = digit_q;
          n = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    // Handle the byte as if nothing were held.
    if (do_fresh) begin
      if ((in_byte_i == CharPercent) && !in_last_i) begin
        held_d = HELD_PCT;
      end else begin
        job.bytes[n] = ((in_byte_i == CharPlus) && plus_to_space_i) ? CharSpace : in_byte_i;
        n = n + 2'd1;
      end
    end
    job.count = n;
    job.last  = in_last_i;
  end

  assign push_o     = accept && (n != 2'd0);
  assign push_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= HELD_NONE;
      digit_q <= 8'd0;
    end else if (accept) begin
      held_q  <= held_d;
      digit_q <= digit_d;
    end
  end

  // A held digit is always a hex character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == HELD_DIGIT) |-> is_hex(digit_q))
    else $error("held digit is not hex");

endmodule

`default_nettype wire

[src/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue: job queue
// Small FIFO of decoded-byte jobs between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue #(
  parameter int unsigned Depth = upd_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire upd_pkg::job_t push_job_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          empty_o,
  output      upd_pkg::job_t head_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |-> pop_i)
    else $error("push into full job queue");

endmodule

`default_nettype wire

[src/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back: byte emitter
// Walks the head job one byte per cycle into the output register, unless the
// receiver stalls, and pops it after its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire upd_pkg::job_t head_i,
  output      logic          pop_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      logic [7:0]    out_byte_o,
  output      logic          string_end_o,
  output      logic          run_last_o
);
  import upd_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       end_q, rlast_q;
  logic       load, take, final_byte;

  assign load       = !valid_q || out_ready_i;
  assign take       = load && !q_empty_i;
  assign final_byte = (idx_q == (head_i.count - 2'd1));
  assign pop_o      = take && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= !q_empty_i;
      end
      if (take) begin
        idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= head_i.bytes[idx_q];
      rlast_q <= final_byte;
      end_q   <= final_byte && head_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign string_end_o = end_q;
  assign run_last_o   = rlast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && end_q) |-> rlast_q)
    else $error("string end not on the last byte of a job");

endmodule

`default_nettype wire

[src/url_percent_decoder_unit.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: streaming URL percent decoder
// Input stream: one encoded byte per transaction, tlast on the final byte of
// a string. Output stream: one decoded byte per transaction, tlast on the
// final decoded byte of the string, tuser[0] on the last byte produced by a
// given input byte. "%XY" with two hex digits (either case) decodes to one
// byte; a '%' not followed by two hex digits passes through literally. With
// the configuration bit set (reset value), '+' decodes to a space.
// Each input byte yields 0 to 3 output bytes: a '%' and a first hex digit
// are held as lookahead and released when the escape completes or breaks.
// An input byte's output passes through the job queue and then the output
// register. Throughput: one input per cycle while each yields at most one
// byte and the receiver does not stall; the emitter moves one output byte
// per cycle, so an input that yields two or three bytes holds it until all
// of them are out, and the job queue absorbs the difference.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and s_axis_tready drops once the queue is full.
// Reset clears the lookahead, empties the queue and output register, and
// sets plus-to-space. Write the configuration only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_unit #(
  parameter int unsigned QueueDepth = upd_pkg::QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration: bit 0 = plus_to_space
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // Input stream
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  // Output stream
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output      logic       m_axis_tlast,   // string_end
  output      logic [0:0] m_axis_tuser    // [0] run_last
);
  import upd_pkg::*;

  logic plus_q;
  logic push, pop, q_full, q_empty;
  job_t push_job, head_job;

  // Hold the decoding mode; the user must write it only while idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_q <= 1'b1;
    end else if (cfg_we_i) begin
      plus_q <= cfg_wdata_i;
    end
  end

  // Classify input bytes and build jobs.
  upd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .plus_to_space_i (plus_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_byte_i       (s_axis_tdata),
    .in_last_i       (s_axis_tlast),
    .push_o          (push),
    .push_job_o      (push_job),
    .q_full_i        (q_full)
  );

  // Decouple the classifier from the emitter.
  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  // Emit one decoded byte per cycle while the receiver does not stall.
  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .string_end_o (m_axis_tlast),
    .run_last_o   (m_axis_tuser[0])
  );

endmodule

`default_nettype wire
